// ----- sv/dspg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dspg_pkg
// Shared constants and types of the dual step pulse generator.
// ----------------------------------------------------------------------------
package dspg_pkg;

    localparam int unsigned TICKS_PER_SECOND = 1000000;

    // field and state widths
    localparam int PERIOD_W = 20;
    localparam int POS_W    = 32;
    localparam int BAL_W    = 16;
    localparam int TURN_W   = 10;
    localparam int MIN_W    = 10;
    localparam int RATE_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // iterative divider for the tick period, ticks-per-second / rate
    localparam int DIV_W = 32;
    localparam int DVS_W = 17;
    localparam int MAG_W = 17;

    localparam int QDEPTH = 4;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};

    localparam logic signed [BAL_W-1:0]  BAL_LIMIT   = 16'sd16320;
    localparam logic signed [BAL_W-1:0]  BAL_SCALE   = 16'sd16320;
    localparam logic signed [TURN_W:0]   TURN_CENTER = 11'sd500;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd2;

    localparam logic [MIN_W-1:0]  MIN_RATE_RST   = 10'd2;
    localparam logic [RATE_W-1:0] MAX_RATE_RST   = 16'd8500;
    localparam logic [RATE_W-1:0] FULL_SCALE_RST = 16'd5500;

    // item opcodes
    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd3;

    typedef struct packed {
        logic                stop;
        logic                fwd;
        logic [PERIOD_W-1:0] period;
    } dspg_wheel_cmd_t;

    typedef struct packed {
        logic                  tick;
        dspg_wheel_cmd_t [1:0] wheel;
    } dspg_entry_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } dspg_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } dspg_div_rsp_t;

endpackage
`default_nettype wire

// ----- sv/dspg_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dspg interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface dspg_item_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] balance_output;
    logic        [9:0]  turn_value;

    modport source (output valid, output opcode, output balance_output,
                    output turn_value, input ready);
    modport sink   (input valid, input opcode, input balance_output,
                    input turn_value, output ready);
endinterface

interface dspg_result_if;
    logic               valid;
    logic               ready;
    logic               step_one;
    logic               step_two;
    logic               dir_pin_one;
    logic               dir_pin_two;
    logic               running_one;
    logic               running_two;
    logic signed [31:0] position_one;
    logic signed [31:0] position_two;

    modport source (output valid, output step_one, output step_two,
                    output dir_pin_one, output dir_pin_two, output running_one,
                    output running_two, output position_one, output position_two,
                    input ready);
    modport sink   (input valid, input step_one, input step_two,
                    input dir_pin_one, input dir_pin_two, input running_one,
                    input running_two, input position_one, input position_two,
                    output ready);
endinterface

interface dspg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/dual_step_pulse_generator_unit.sv -----
`default_nettype none
// tick items: one per cycle while the front is idle and the fifo is not full, result
//   via the fifo in the output register; speed commands: one quotient per wheel in the
//   serial divider (ticks-per-second / rate); a stopping wheel skips it
// items queue in order behind a 4-entry fifo; ticks stall while a command is in the front
// reset (rst_n low, async): wheels stopped, positions zero, config at its default values
// ----------------------------------------------------------------------------
// dual_step_pulse_generator_unit
// Two-channel step/direction generator with differential speed mixing.
// ----------------------------------------------------------------------------
module dual_step_pulse_generator_unit import dspg_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dspg_item_if.sink     item,
    dspg_cfg_if.sink      cfg,
    dspg_result_if.source result
);

    logic          push;
    logic          full;
    logic          pop;
    logic          empty;
    dspg_entry_t   push_data;
    dspg_entry_t   pop_data;
    dspg_div_req_t div_req;
    dspg_div_rsp_t div_rsp;

    dspg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg       (cfg),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

    dspg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    dspg_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    dspg_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .entry  (pop_data),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule
`default_nettype wire

// ----- sv/dspg_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dspg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dspg_div import dspg_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dspg_div_req_t req,
    output dspg_div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] q_reg, q_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             ge;

    always_comb
    begin
        shifted = {rem_reg, q_reg[DIV_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = (shifted >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DIV_W-2:0], ge};
            rem_next = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule
`default_nettype wire

// ----- sv/dspg_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dspg_fifo
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module dspg_fifo import dspg_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire dspg_entry_t push_data,
    output logic       full,
    input  wire logic  pop,
    output dspg_entry_t pop_data,
    output logic       empty
);

    localparam int PTR_W = $clog2(QDEPTH);

    dspg_entry_t      mem [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem[rd_ptr_reg];
    assign full     = (count_reg == (PTR_W+1)'(QDEPTH));
    assign empty    = (count_reg == '0);

endmodule
`default_nettype wire

// ----- sv/dspg_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dspg_front
// Takes items and config writes, turns speed commands into periods.
// ----------------------------------------------------------------------------
module dspg_front import dspg_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    dspg_item_if.sink    item,
    dspg_cfg_if.sink     cfg,
    output logic         push,
    output dspg_entry_t  push_data,
    input  wire logic    full,
    output dspg_div_req_t div_req,
    input  wire dspg_div_rsp_t div_rsp
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIVM = 3'd3;
    localparam logic [2:0] ST_CHK  = 3'd4;
    localparam logic [2:0] ST_DIVP = 3'd5;
    localparam logic [2:0] ST_PUSH = 3'd6;

    localparam logic [DIV_W-1:0] TPS_DIVIDEND = DIV_W'(TICKS_PER_SECOND);

    // |mix| / 16320 is (|mix| >> 6) / 255, the latter as a multiply by
    // ceil(2^33 / 255) and a shift, exact for the 25-bit operand
    localparam logic [25:0] MAG_RECIP = 26'd33686019;

    logic [2:0]               state_reg, state_next;
    logic                     wheel_reg, wheel_next;
    logic signed [BAL_W-1:0]  bal_reg, bal_next;
    logic signed [TURN_W:0]   turn_reg, turn_next;
    logic signed [32:0]       base_reg, base_next;
    logic signed [32:0]       off_reg, off_next;
    logic                     fwd_reg, fwd_next;
    logic [24:0]              abs_reg, abs_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    dspg_wheel_cmd_t [1:0]    cmd_reg, cmd_next;

    logic [MIN_W-1:0]         min_rate_reg;
    logic [RATE_W-1:0]        max_rate_reg;
    logic [RATE_W-1:0]        full_scale_reg;

    logic                     accept;
    logic signed [BAL_W-1:0]  bal_clamped;
    logic signed [32:0]       num;
    logic [32:0]              num_abs;
    logic [50:0]              mag_prod;
    logic [RATE_W-1:0]        sat;
    logic                     stop;
    logic [PERIOD_W-1:0]      period;

    assign item.ready = (state_reg == ST_IDLE) && !full;
    assign cfg.ready  = 1'b1;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        if (item.balance_output > BAL_LIMIT)
        begin
            bal_clamped = BAL_LIMIT;
        end
        else if (item.balance_output < -BAL_LIMIT)
        begin
            bal_clamped = -BAL_LIMIT;
        end
        else
        begin
            bal_clamped = item.balance_output;
        end
    end

    // per wheel mix, wheel two takes the turn offset negated
    always_comb
    begin
        num      = wheel_reg ? (base_reg - off_reg) : (base_reg + off_reg);
        num_abs  = num[32] ? 33'(-num) : 33'(num);
        mag_prod = 51'(abs_reg) * 51'(MAG_RECIP);
    end

    always_comb
    begin
        sat  = (mag_reg > {1'b0, max_rate_reg}) ? max_rate_reg : mag_reg[RATE_W-1:0];
        stop = (mag_reg < MAG_W'(min_rate_reg)) || (mag_reg == '0) || (sat == '0);

        if (div_rsp.quotient == '0)
        begin
            period = PERIOD_W'(1);
        end
        else if (div_rsp.quotient > DIV_W'(PERIOD_MAX))
        begin
            period = PERIOD_MAX;
        end
        else
        begin
            period = div_rsp.quotient[PERIOD_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        wheel_next = wheel_reg;
        bal_next   = bal_reg;
        turn_next  = turn_reg;
        base_next  = base_reg;
        off_next   = off_reg;
        fwd_next   = fwd_reg;
        abs_next   = abs_reg;
        mag_next   = mag_reg;
        cmd_next   = cmd_reg;

        div_req.start    = 1'b0;
        div_req.dividend = TPS_DIVIDEND;
        div_req.divisor  = DVS_W'(sat);

        push           = 1'b0;
        push_data.tick = 1'b1;
        push_data.wheel = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.opcode == OP_TICK)
                    begin
                        push = 1'b1;
                    end
                    else
                    begin
                        bal_next   = bal_clamped;
                        turn_next  = $signed({1'b0, item.turn_value}) - TURN_CENTER;
                        wheel_next = 1'b0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                base_next  = bal_reg * $signed({1'b0, full_scale_reg});
                off_next   = turn_reg * BAL_SCALE;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                fwd_next   = !num[32] && (num != '0);
                abs_next   = num_abs[30:6];
                state_next = ST_DIVM;
            end
            ST_DIVM:
            begin
                mag_next   = mag_prod[49:33];
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (stop)
                begin
                    cmd_next[wheel_reg].stop   = 1'b1;
                    cmd_next[wheel_reg].fwd    = 1'b0;
                    cmd_next[wheel_reg].period = '0;
                    wheel_next = 1'b1;
                    state_next = wheel_reg ? ST_PUSH : ST_SUM;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIVP;
                end
            end
            ST_DIVP:
            begin
                if (div_rsp.done)
                begin
                    cmd_next[wheel_reg].stop   = 1'b0;
                    cmd_next[wheel_reg].fwd    = fwd_reg;
                    cmd_next[wheel_reg].period = period;
                    wheel_next = 1'b1;
                    state_next = wheel_reg ? ST_PUSH : ST_SUM;
                end
            end
            ST_PUSH:
            begin
                push_data.tick  = 1'b0;
                push_data.wheel = cmd_reg;
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            min_rate_reg   <= MIN_RATE_RST;
            max_rate_reg   <= MAX_RATE_RST;
            full_scale_reg <= FULL_SCALE_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_MIN_RATE:   min_rate_reg   <= cfg.data[MIN_W-1:0];
                    REG_MAX_RATE:   max_rate_reg   <= cfg.data;
                    REG_FULL_SCALE: full_scale_reg <= cfg.data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wheel_reg <= wheel_next;
        bal_reg   <= bal_next;
        turn_reg  <= turn_next;
        base_reg  <= base_next;
        off_reg   <= off_next;
        fwd_reg   <= fwd_next;
        abs_reg   <= abs_next;
        mag_reg   <= mag_next;
        cmd_reg   <= cmd_next;
    end

endmodule
`default_nettype wire

// ----- sv/dspg_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dspg_back
// Wheel timers, step pulses and positions; drives the result channel.
// ----------------------------------------------------------------------------
module dspg_back import dspg_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire dspg_entry_t entry,
    input  wire logic     empty,
    output logic          pop,
    dspg_result_if.source result
);

    // wheel two drives its direction pin inverted
    localparam logic [1:0] PIN_INVERT = 2'b10;

    logic [PERIOD_W-1:0] period_reg [2];
    logic [PERIOD_W-1:0] period_next [2];
    logic [PERIOD_W-1:0] count_reg [2];
    logic [PERIOD_W-1:0] count_next [2];
    logic [PERIOD_W-1:0] cnt_inc [2];
    logic [1:0]          dir_reg [2];
    logic [1:0]          dir_next [2];
    logic [POS_W-1:0]    steps_reg [2];
    logic [POS_W-1:0]    steps_next [2];
    logic [1:0]          run_reg, run_next;
    logic [1:0]          pin_reg, pin_next;
    logic [1:0]          step_reg, step_next;
    logic                res_valid_reg, res_valid_next;

    // wheel state only moves on a pop, so it stands as the result until taken
    assign pop = !empty && (!res_valid_reg || result.ready);

    always_comb
    begin
        run_next  = run_reg;
        pin_next  = pin_reg;
        step_next = step_reg;
        for (int i = 0; i < 2; i++)
        begin
            period_next[i] = period_reg[i];
            count_next[i]  = count_reg[i];
            dir_next[i]    = dir_reg[i];
            steps_next[i]  = steps_reg[i];
            cnt_inc[i]     = count_reg[i] + 1'b1;

            if (pop)
            begin
                step_next[i] = 1'b0;
                if (entry.tick)
                begin
                    if (run_reg[i])
                    begin
                        count_next[i] = cnt_inc[i];
                        if (cnt_inc[i] >= period_reg[i])
                        begin
                            count_next[i] = '0;
                            step_next[i]  = 1'b1;
                            if (dir_reg[i] == DIR_FWD)
                            begin
                                steps_next[i] = steps_reg[i] + 1'b1;
                            end
                            else if (dir_reg[i] == DIR_BACK)
                            begin
                                steps_next[i] = steps_reg[i] - 1'b1;
                            end
                        end
                    end
                end
                else if (entry.wheel[i].stop)
                begin
                    run_next[i]    = 1'b0;
                    period_next[i] = '0;
                    dir_next[i]    = DIR_NONE;
                end
                else
                begin
                    run_next[i]    = 1'b1;
                    period_next[i] = entry.wheel[i].period;
                    dir_next[i]    = entry.wheel[i].fwd ? DIR_FWD : DIR_BACK;
                    if (dir_next[i] != dir_reg[i])
                    begin
                        pin_next[i] = entry.wheel[i].fwd ^ PIN_INVERT[i];
                    end
                end
            end
        end

        if (pop)
        begin
            res_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                period_reg[i] <= '0;
                count_reg[i]  <= '0;
                dir_reg[i]    <= DIR_NONE;
                steps_reg[i]  <= '0;
            end
            run_reg       <= '0;
            pin_reg       <= '0;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 2; i++)
            begin
                period_reg[i] <= period_next[i];
                count_reg[i]  <= count_next[i];
                dir_reg[i]    <= dir_next[i];
                steps_reg[i]  <= steps_next[i];
            end
            run_reg       <= run_next;
            pin_reg       <= pin_next;
            step_reg      <= step_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.step_one     = step_reg[0];
    assign result.step_two     = step_reg[1];
    assign result.dir_pin_one  = pin_reg[0];
    assign result.dir_pin_two  = pin_reg[1];
    assign result.running_one  = run_reg[0];
    assign result.running_two  = run_reg[1];
    assign result.position_one = $signed(steps_reg[0]);
    assign result.position_two = $signed(steps_reg[1]);

endmodule
`default_nettype wire

// ----- sv/dspg_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dspg_checker
// Port-level checks of the step pulse generator.
// ----------------------------------------------------------------------------
module dspg_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        step_one,
    input wire logic        running_one,
    input wire logic [31:0] position_one,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    logic        have_reg;
    logic [31:0] last_pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            last_pos_reg <= position_one;
        end
    end

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(position_one) && $stable(step_one))
        else $error("result changed while stalled");

    a_step_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && step_one |-> running_one)
        else $error("step pulse on a stopped wheel");

    // position moves only with a step pulse
    a_pos_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && have_reg && !step_one |-> position_one == last_pos_reg)
        else $error("position moved without a step");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind dual_step_pulse_generator_unit dspg_checker u_dspg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .step_one     (result.step_one),
    .running_one  (result.running_one),
    .position_one (result.position_one),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready)
);
`default_nettype wire

// ----- tb/sv/dual_step_pulse_generator_unit_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dual_step_pulse_generator_unit_tb
// Self-checking bench: speed commands and ticks go in over the item channel,
// a local model of both wheels predicts every status transaction, and each
// transaction coming back is compared field by field under random stalls.
// ----------------------------------------------------------------------------
module dual_step_pulse_generator_unit_tb;
    import dspg_pkg::*;

    typedef struct packed {
        logic              step_one;
        logic              step_two;
        logic              dir_pin_one;
        logic              dir_pin_two;
        logic              running_one;
        logic              running_two;
        logic [POS_W-1:0]  position_one;
        logic [POS_W-1:0]  position_two;
    } drive_status_t;

    typedef struct {
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] count;
        logic                run;
        logic [1:0]          dir;
        logic [POS_W-1:0]    steps;
        logic                pin;
    } wheel_model_t;

    logic clk;
    logic rst_n;

    dspg_item_if   item_ch ();
    dspg_cfg_if    cfg_ch ();
    dspg_result_if result_ch ();

    dual_step_pulse_generator_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .cfg    (cfg_ch),
        .result (result_ch)
    );

    // model of both wheels and of the rate registers
    wheel_model_t     wheel_m [2];
    logic [MIN_W-1:0]  min_rate;
    logic [RATE_W-1:0] max_rate;
    logic [RATE_W-1:0] full_scale;

    drive_status_t status_q [$];
    drive_status_t want_status;
    int            mismatch_count;
    int            idle_pct;
    int            stall_pct;
    int            hold_off_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(name, got, want);
    endtask

    function automatic void set_wheel_rate(input int w, input longint mix);
        longint     mag;
        longint     per;
        logic [1:0] d;
        mag = (mix < 0 ? -mix : mix) / longint'(BAL_SCALE);
        // a zero max rate saturates every rate to zero, which stops the wheel too
        if (mag < longint'(min_rate) || mag == 0 || max_rate == '0)
        begin
            wheel_m[w].run    = 1'b0;
            wheel_m[w].period = '0;
            wheel_m[w].dir    = DIR_NONE;
        end
        else
        begin
            if (mag > longint'(max_rate))
                mag = longint'(max_rate);
            per = longint'(TICKS_PER_SECOND) / mag;
            if (per == 0)
                per = 1;
            if (per > longint'(PERIOD_MAX))
                per = longint'(PERIOD_MAX);
            d = (mix > 0) ? DIR_FWD : DIR_BACK;
            // pin only follows a change of direction; wheel two is wired inverted
            if (d != wheel_m[w].dir)
            begin
                wheel_m[w].pin = (w == 0) ? (d == DIR_FWD) : (d == DIR_BACK);
                wheel_m[w].dir = d;
            end
            wheel_m[w].period = per[PERIOD_W-1:0];
            wheel_m[w].run    = 1'b1;
        end
    endfunction

    function automatic drive_status_t predict_status(input logic op,
                                                     input logic signed [BAL_W-1:0] bal,
                                                     input logic [TURN_W-1:0] turn);
        drive_status_t s;
        longint        b;
        longint        base;
        longint        offset;
        logic [1:0]    stepped;
        stepped = 2'b00;
        if (op == OP_CMD)
        begin
            b = bal;
            if (b > longint'(BAL_LIMIT))
                b = longint'(BAL_LIMIT);
            if (b < -longint'(BAL_LIMIT))
                b = -longint'(BAL_LIMIT);
            base   = b * longint'(full_scale);
            offset = (longint'(turn) - longint'(TURN_CENTER)) * longint'(BAL_SCALE);
            set_wheel_rate(0, base + offset);
            set_wheel_rate(1, base - offset);
        end
        else
        begin
            for (int w = 0; w < 2; w++)
            begin
                if (wheel_m[w].run)
                begin
                    wheel_m[w].count = wheel_m[w].count + 1'b1;
                    // a shortened period can leave the counter already past it
                    if (wheel_m[w].count >= wheel_m[w].period)
                    begin
                        wheel_m[w].count = '0;
                        if (wheel_m[w].dir == DIR_FWD)
                            wheel_m[w].steps = wheel_m[w].steps + 1'b1;
                        else if (wheel_m[w].dir == DIR_BACK)
                            wheel_m[w].steps = wheel_m[w].steps - 1'b1;
                        stepped[w] = 1'b1;
                    end
                end
            end
        end
        s.step_one     = stepped[0];
        s.step_two     = stepped[1];
        s.dir_pin_one  = wheel_m[0].pin;
        s.dir_pin_two  = wheel_m[1].pin;
        s.running_one  = wheel_m[0].run;
        s.running_two  = wheel_m[1].run;
        s.position_one = wheel_m[0].steps;
        s.position_two = wheel_m[1].steps;
        return s;
    endfunction

    // receiver: random stalls, or one long hold-off counted here
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (status_q.size() == 0)
                report_mismatch("status transaction with none pending", 32'd0, 32'd0);
            else
            begin
                want_status = status_q.pop_front();
                check_field("step_one", result_ch.step_one, want_status.step_one);
                check_field("step_two", result_ch.step_two, want_status.step_two);
                check_field("dir_pin_one", result_ch.dir_pin_one, want_status.dir_pin_one);
                check_field("dir_pin_two", result_ch.dir_pin_two, want_status.dir_pin_two);
                check_field("running_one", result_ch.running_one, want_status.running_one);
                check_field("running_two", result_ch.running_two, want_status.running_two);
                check_field("position_one", result_ch.position_one,
                            want_status.position_one);
                check_field("position_two", result_ch.position_two,
                            want_status.position_two);
            end
        end
    end

    task automatic send_item(input logic op, input logic signed [BAL_W-1:0] bal,
                             input logic [TURN_W-1:0] turn);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.opcode         <= op;
        item_ch.balance_output <= bal;
        item_ch.turn_value     <= turn;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        status_q.push_back(predict_status(op, bal, turn));
    endtask

    task automatic send_tick;
        // payload of a tick is ignored, so it carries noise
        send_item(OP_TICK, BAL_W'($urandom()), TURN_W'($urandom()));
    endtask

    task automatic wait_drained;
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (status_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_MIN_RATE:   min_rate   = value[MIN_W-1:0];
            REG_MAX_RATE:   max_rate   = value[RATE_W-1:0];
            REG_FULL_SCALE: full_scale = value[RATE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_rates(input logic [CFG_DAT_W-1:0] min_v, input logic [CFG_DAT_W-1:0] max_v,
                             input logic [CFG_DAT_W-1:0] full_v);
        wait_drained();
        write_reg(REG_MIN_RATE, min_v);
        write_reg(REG_MAX_RATE, max_v);
        write_reg(REG_FULL_SCALE, full_v);
    endtask

    task automatic send_random_command;
        int                      pick;
        int                      mag_i;
        logic signed [BAL_W-1:0] bal;
        logic [TURN_W-1:0]       turn;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            bal  = BAL_W'($urandom());
            turn = TURN_W'($urandom());
        end
        else if (pick == 2)
        begin
            // near standstill, around the minimum rate
            mag_i = int'($urandom_range(0, 400)) - 200;
            bal   = BAL_W'(mag_i);
            turn  = TURN_W'($urandom_range(490, 510));
        end
        else
        begin
            mag_i = int'($urandom_range(3000, 16400));
            if ($urandom_range(0, 1) == 1)
                mag_i = -mag_i;
            bal  = BAL_W'(mag_i);
            turn = TURN_W'($urandom_range(0, 1000));
        end
        send_item(OP_CMD, bal, turn);
    endtask

    task automatic test_field_extremes;
        send_item(OP_CMD, 16'sh7fff, 10'd1000);
        send_item(OP_TICK, 16'sh8000, 10'h3ff);
        send_item(OP_CMD, 16'sh8000, 10'd0);
        send_item(OP_CMD, 16'sd16320, 10'd500);
        send_item(OP_CMD, -16'sd16320, 10'd500);
        send_item(OP_CMD, 16'sd0, 10'd1023);
    endtask

    task automatic test_stop_cases;
        send_item(OP_CMD, 16'sd0, 10'd500);
        // wheel one lands on the minimum rate, wheel two truncates to zero
        send_item(OP_CMD, 16'sd5, 10'd501);
        send_item(OP_CMD, 16'sd0, 10'd499);
        set_rates(16'(MIN_RATE_RST), 16'd0, 16'(FULL_SCALE_RST));
        send_item(OP_CMD, 16'sd16320, 10'd600);
        set_rates(16'(MIN_RATE_RST), 16'(MAX_RATE_RST), 16'(FULL_SCALE_RST));
    endtask

    task automatic test_period_change;
        set_rates(16'd1, 16'd65535, 16'd65535);
        send_item(OP_CMD, 16'sd8000, 10'd500);
        repeat (15) send_tick();
        // period no longer than the running count: steps on the next tick
        send_item(OP_CMD, 16'sd16320, 10'd500);
        send_tick();
        send_item(OP_CMD, -16'sd16320, 10'd500);
        send_tick();
    endtask

    task automatic test_input_backpressure;
        wait_drained();
        hold_off_cycles = 300;
        repeat (24) send_tick();
        wait_drained();
    endtask

    task automatic run_random_phase(input logic [CFG_DAT_W-1:0] min_v,
                                    input logic [CFG_DAT_W-1:0] max_v,
                                    input logic [CFG_DAT_W-1:0] full_v,
                                    input int idle, input int stall, input int count);
        int sent;
        int burst;
        bit paused;
        set_rates(min_v, max_v, full_v);
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        paused    = 1'b0;
        while (sent < count)
        begin
            send_random_command();
            burst = $urandom_range(3, 40);
            repeat (burst) send_tick();
            sent += burst + 1;
            if (!paused && sent >= count / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        int drain_cycles;
        rst_n                  = 1'b0;
        item_ch.valid          = 1'b0;
        item_ch.opcode         = OP_TICK;
        item_ch.balance_output = '0;
        item_ch.turn_value     = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = REG_MIN_RATE;
        cfg_ch.data            = '0;
        mismatch_count         = 0;
        idle_pct               = 0;
        stall_pct              = 0;
        hold_off_cycles        = 0;
        min_rate               = MIN_RATE_RST;
        max_rate               = MAX_RATE_RST;
        full_scale             = FULL_SCALE_RST;
        for (int w = 0; w < 2; w++)
        begin
            wheel_m[w].period = '0;
            wheel_m[w].count  = '0;
            wheel_m[w].run    = 1'b0;
            wheel_m[w].dir    = DIR_NONE;
            wheel_m[w].steps  = '0;
            wheel_m[w].pin    = 1'b0;
        end
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_stop_cases();
        test_period_change();
        test_input_backpressure();
        run_random_phase(16'(MIN_RATE_RST), 16'(MAX_RATE_RST), 16'(FULL_SCALE_RST), 0, 0, 100);
        run_random_phase(16'd1, 16'd65535, 16'd65535, 68, 0, 100);
        run_random_phase(16'd1000, 16'd65535, 16'd30000, 0, 68, 90);
        run_random_phase(16'd1, 16'd1, 16'd0, 30, 30, 40);
        run_random_phase(16'($urandom_range(1, 1000)), 16'($urandom_range(100, 65535)),
                         16'($urandom_range(0, 65535)), 30, 30, 100);

        @(negedge clk);
        item_ch.valid <= 1'b0;
        drain_cycles = 0;
        while (status_q.size() != 0 && drain_cycles < 50000)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (20) @(negedge clk);
        if (status_q.size() != 0)
            report_mismatch("status transactions never returned", 32'(status_q.size()), 32'd0);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
